[rtl/core/sema_pkg.sv]
// Shared types and constants for the sensor EMA plausibility block.
// Used by sema_lane, sema_merge and sensor_ema_plausibility; no dependencies.
`timescale 1ns / 1ps

package sema_pkg;

  localparam int AdcBitsDef = 12;
  localparam int RawW       = 12;
  localparam int GainW      = 24;
  localparam int AlphaW     = 17;
  localparam int FixW       = 18;
  localparam int StreakW    = 8;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 24;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 56;
  localparam int OutUserW   = 2;

  localparam int FixMax = 131071;
  localparam int FixMin = -131072;

  // Plausibility windows in 1/256 units, inclusive.
  localparam logic signed [FixW-1:0] VbatLo = 18'sd0;
  localparam logic signed [FixW-1:0] VbatHi = 18'sd5120;
  localparam logic signed [FixW-1:0] CurLo  = 18'sd0;
  localparam logic signed [FixW-1:0] CurHi  = 18'sd1792;
  localparam logic signed [FixW-1:0] TempLo = -18'sd5120;
  localparam logic signed [FixW-1:0] TempHi = 18'sd38400;

  localparam logic [AlphaW-1:0]  AlphaRst   = 17'd6554;
  localparam logic [GainW-1:0]   VbatGainRst = 24'd54080;
  localparam logic [GainW-1:0]   CurGainRst  = 24'd13520;
  localparam logic [GainW-1:0]   TempGainRst = 24'd1352010;
  localparam logic [StreakW-1:0] StartupRst  = 8'd10;

  typedef enum logic [CfgAddrW-1:0] {
    CfgAlpha    = 3'd0,
    CfgVbatGain = 3'd1,
    CfgCurGain  = 3'd2,
    CfgTempGain = 3'd3,
    CfgStartup  = 3'd4
  } cfg_reg_e;

  // Stage strobes shared by all three lanes.
  typedef struct packed {
    logic capture;  // a set is transferred in: register the scaling product
    logic step;     // form the scaled value and the weighted difference
    logic commit;   // update the filter state
    logic primed;   // filter already holds a value
  } lane_ctrl_t;

  typedef struct packed {
    logic                   ready;
    logic                   valid;
    logic signed [FixW-1:0] temp;
    logic signed [FixW-1:0] cur;
    logic signed [FixW-1:0] vbat;
  } result_t;

endpackage

[rtl/core/sema_lane.sv]
// One filter lane: scales a raw ADC code by its gain and runs the EMA update.
// Depends on sema_pkg; three instances sit side by side in the top level.
`timescale 1ns / 1ps

module sema_lane import sema_pkg::*; #(
  parameter int AdcBits = AdcBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lane_ctrl_t             ctrl_i,
  input  logic [RawW-1:0]        raw_i,
  input  logic [GainW-1:0]       gain_i,
  input  logic [AlphaW-1:0]      alpha_i,
  output logic signed [FixW-1:0] state_o
);

  localparam int CodeW = (AdcBits < RawW) ? AdcBits : RawW;
  localparam int ProdW = CodeW + GainW;
  localparam int MulW  = AlphaW + 1 + FixW + 1;
  localparam int StepW = MulW - 16;

  logic [ProdW-1:0]       prod_q, prod_d;
  logic [23:0]            shifted;
  logic signed [FixW-1:0] scaled_d, scaled_q;
  logic signed [FixW:0]   diff;
  logic signed [MulW-1:0] alpha_ext, diff_ext, wprod_d, wprod_q;
  logic signed [StepW-1:0] step;
  logic signed [StepW:0]  sum;
  logic signed [FixW-1:0] ema_d, state_q, state_d;

  assign prod_d = ProdW'(raw_i[CodeW-1:0]) * ProdW'(gain_i);

  always_comb begin
    shifted = 24'(prod_q[ProdW-1:16]);
    if (shifted > 24'(FixMax)) begin
      scaled_d = FixW'(FixMax);
    end else begin
      scaled_d = shifted[FixW-1:0];
    end
    diff      = {scaled_d[FixW-1], scaled_d} - {state_q[FixW-1], state_q};
    alpha_ext = MulW'($signed({1'b0, alpha_i}));
    diff_ext  = MulW'(diff);
    wprod_d   = alpha_ext * diff_ext;
  end

  // Dropping the low sixteen bits of a two's complement value rounds towards minus infinity.
  always_comb begin
    step = wprod_q[MulW-1:16];
    sum  = {state_q[FixW-1], StepW'(state_q)} + {step[StepW-1], step};
    if (sum > (StepW+1)'(FixMax)) begin
      ema_d = FixW'(FixMax);
    end else if (sum < (StepW+1)'(FixMin)) begin
      ema_d = FixW'(FixMin);
    end else begin
      ema_d = sum[FixW-1:0];
    end
    state_d = ctrl_i.primed ? ema_d : scaled_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.step) begin
      scaled_q <= scaled_d;
      wprod_q  <= wprod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (ctrl_i.commit) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

[rtl/core/sema_merge.sv]
// Merge stage: checks the three filtered values against their windows,
// keeps the valid streak and registers the result. Depends on sema_pkg.
`timescale 1ns / 1ps

module sema_merge import sema_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic signed [FixW-1:0] vbat_i,
  input  logic signed [FixW-1:0] cur_i,
  input  logic signed [FixW-1:0] temp_i,
  input  logic [StreakW-1:0]     startup_i,
  output result_t                res_o
);

  logic               ok;
  logic               ready;
  logic [StreakW-1:0] streak_q, streak_d;
  result_t            res_q, res_d;

  always_comb begin
    ok = (vbat_i >= VbatLo) && (vbat_i <= VbatHi) &&
         (cur_i  >= CurLo)  && (cur_i  <= CurHi)  &&
         (temp_i >= TempLo) && (temp_i <= TempHi);
    if (!ok) begin
      streak_d = '0;
    end else if (streak_q < startup_i) begin
      streak_d = streak_q + StreakW'(1);
    end else begin
      streak_d = streak_q;
    end
    ready       = ok && (streak_d >= startup_i);
    res_d.ready = ready;
    res_d.valid = ok;
    res_d.temp  = temp_i;
    res_d.cur   = cur_i;
    res_d.vbat  = vbat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streak_q <= '0;
    end else if (fire_i) begin
      streak_q <= streak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/core/sensor_ema_plausibility.sv]
// Top level of the sensor EMA plausibility block: configuration registers,
// stage control, three sema_lane instances and sema_merge. Depends on sema_pkg.
//
// Usage:
//   s_axis carries one set of three raw ADC codes per transfer. m_axis returns
//   one result per set: the three filtered values in tdata and the flags
//   sample_valid and sensors_ready in tuser. The cfg channel writes one
//   register per transfer (index from cfg_reg_e) and is always ready; the user
//   must write it only while no set is in flight; the block does not enforce it.
//   Three lanes scale and filter the channels in parallel: the scaling multiply,
//   then the weighted-difference multiply, then the state update, each into its
//   own register, then the merge stage registers the checked result.
//   One set is in flight at a time, so the block takes no new set before the
//   last one is through: the input stays closed while the three lane stages run
//   and reopens once the merge stage has taken the result.
//   Reset clears the filter states, the primed flag and the streak, and loads
//   the register defaults. When the receiver stalls, the finished result is
//   held and the block still takes the next set; that set then waits in the
//   last lane stage until the output register frees.
`timescale 1ns / 1ps

module sensor_ema_plausibility import sema_pkg::*; #(
  parameter int AdcBits = AdcBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // raw_vbat_code [11:0], raw_current_code [23:12], raw_temp_code [35:24], zero pad
  input  logic [InDataW-1:0]    s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // vbat_filtered [17:0], current_filtered [35:18], temp_filtered [53:36], zero pad
  output logic [OutDataW-1:0]   m_axis_tdata_o,
  // sample_valid [0], sensors_ready [1]
  output logic [OutUserW-1:0]   m_axis_tuser_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgAddrW-1:0]   cfg_addr_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  logic [AlphaW-1:0]  alpha_q;
  logic [GainW-1:0]   vbat_gain_q, cur_gain_q, temp_gain_q;
  logic [StreakW-1:0] startup_q;

  logic st1_q, st2_q, st3_q, st3_d;
  logic primed_q;
  logic out_valid_q, out_valid_d;
  logic in_fire, out_free, merge_fire, busy;

  lane_ctrl_t ctrl;
  result_t    res;
  logic signed [FixW-1:0] vbat_state, cur_state, temp_state;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= AlphaRst;
      vbat_gain_q <= VbatGainRst;
      cur_gain_q  <= CurGainRst;
      temp_gain_q <= TempGainRst;
      startup_q   <= StartupRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CfgAlpha:    alpha_q     <= cfg_data_i[AlphaW-1:0];
        CfgVbatGain: vbat_gain_q <= cfg_data_i;
        CfgCurGain:  cur_gain_q  <= cfg_data_i;
        CfgTempGain: temp_gain_q <= cfg_data_i;
        CfgStartup:  startup_q   <= cfg_data_i[StreakW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    busy            = st1_q | st2_q | st3_q;
    s_axis_tready_o = !busy;
    in_fire         = s_axis_tvalid_i && s_axis_tready_o;
    out_free        = !out_valid_q || m_axis_tready_i;
    merge_fire      = st3_q && out_free;
    st3_d           = st2_q || (st3_q && !out_free);
    if (merge_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    ctrl.capture = in_fire;
    ctrl.step    = st1_q;
    ctrl.commit  = st2_q;
    ctrl.primed  = primed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q       <= 1'b0;
      st2_q       <= 1'b0;
      st3_q       <= 1'b0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st1_q       <= in_fire;
      st2_q       <= st1_q;
      st3_q       <= st3_d;
      out_valid_q <= out_valid_d;
      if (st2_q) begin
        primed_q <= 1'b1;
      end
    end
  end

  sema_lane #(.AdcBits(AdcBits)) u_lane_vbat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .raw_i   (s_axis_tdata_i[RawW-1:0]),
    .gain_i  (vbat_gain_q),
    .alpha_i (alpha_q),
    .state_o (vbat_state)
  );

  sema_lane #(.AdcBits(AdcBits)) u_lane_cur (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .raw_i   (s_axis_tdata_i[2*RawW-1:RawW]),
    .gain_i  (cur_gain_q),
    .alpha_i (alpha_q),
    .state_o (cur_state)
  );

  sema_lane #(.AdcBits(AdcBits)) u_lane_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .raw_i   (s_axis_tdata_i[3*RawW-1:2*RawW]),
    .gain_i  (temp_gain_q),
    .alpha_i (alpha_q),
    .state_o (temp_state)
  );

  sema_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (merge_fire),
    .vbat_i    (vbat_state),
    .cur_i     (cur_state),
    .temp_i    (temp_state),
    .startup_i (startup_q),
    .res_o     (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - 3*FixW)'(0), res.temp, res.cur, res.vbat};
  assign m_axis_tuser_o  = {res.ready, res.valid};

  // Only one set may be in flight inside the lanes.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0({st1_q, st2_q, st3_q}))
    else $error("more than one lane stage active");

  // A transfer in must reach the step stage on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> st1_q)
    else $error("accepted set did not enter the lanes");

  // Ready is never reported for an implausible set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tuser_o[0])
    else $error("sensors_ready without sample_valid");

  // After any set has been committed, the filter stays primed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) st3_q |-> primed_q)
    else $error("result stage active with unprimed filter");

endmodule

[tb/sensor_ema_plausibility_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sensor_ema_plausibility: sets of raw ADC codes go in
// over s_axis, and every filtered result is compared against a predictor kept here.
// Depends on sema_pkg and the block's RTL only.

module sensor_ema_plausibility_tb;
  import sema_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 7;
  localparam int RandomPhases = 8;
  localparam int SetsPerPhase = 85;
  localparam int DrainCycles  = 2000;
  localparam int TailCycles   = 20;
  localparam int MaxPrinted   = 100;

  typedef struct packed {
    logic [RawW-1:0] temp;
    logic [RawW-1:0] cur;
    logic [RawW-1:0] vbat;
  } raw_set_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_e            cfg_addr  = CfgAlpha;
  logic [CfgDataW-1:0] cfg_data  = '0;

  sensor_ema_plausibility dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Copy of the block's registers and filter state.
  logic [AlphaW-1:0]      alpha_m;
  logic [GainW-1:0]       vbat_gain_m, cur_gain_m, temp_gain_m;
  logic [StreakW-1:0]     startup_m;
  logic signed [FixW-1:0] vbat_acc, cur_acc, temp_acc;
  logic                   primed;
  logic [StreakW-1:0]     streak;

  raw_set_t sets_to_send[$];
  result_t  results_due[$];
  bit       set_taken = 1'b0;
  bit       src_calm  = 1'b0;
  bit       snk_calm  = 1'b0;
  int       src_gap   = 0;
  int       snk_stall = 0;
  int       sets_in, results_out, plausible_seen, ready_seen, phases, fail_count;

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MaxPrinted) $display("MISMATCH %s", msg);
  endtask

  function automatic logic signed [FixW-1:0] clamp18(longint v);
    if (v > FixMax) return FixW'(FixMax);
    if (v < FixMin) return FixW'(FixMin);
    return FixW'(v);
  endfunction

  function automatic logic signed [FixW-1:0] scale_code(logic [RawW-1:0] code,
                                                        logic [GainW-1:0] gain);
    longint prod;
    prod = (longint'(code) * longint'(gain)) >>> 16;
    if (prod > FixMax) prod = FixMax;
    return FixW'(prod);
  endfunction

  // The arithmetic shift floors, which is what the filter step needs for negative steps.
  function automatic logic signed [FixW-1:0] smooth(logic signed [FixW-1:0] x,
                                                    logic signed [FixW-1:0] prev);
    longint sum;
    sum = longint'(prev) + ((longint'(alpha_m) * (longint'(x) - longint'(prev))) >>> 16);
    return clamp18(sum);
  endfunction

  function automatic result_t filter_set(raw_set_t s);
    logic signed [FixW-1:0] xv, xc, xt;
    result_t r;
    xv = scale_code(s.vbat, vbat_gain_m);
    xc = scale_code(s.cur, cur_gain_m);
    xt = scale_code(s.temp, temp_gain_m);
    if (!primed) begin
      vbat_acc = xv;
      cur_acc  = xc;
      temp_acc = xt;
      primed   = 1'b1;
    end else begin
      vbat_acc = smooth(xv, vbat_acc);
      cur_acc  = smooth(xc, cur_acc);
      temp_acc = smooth(xt, temp_acc);
    end
    r.vbat  = vbat_acc;
    r.cur   = cur_acc;
    r.temp  = temp_acc;
    r.valid = vbat_acc >= VbatLo && vbat_acc <= VbatHi && cur_acc >= CurLo &&
              cur_acc <= CurHi && temp_acc >= TempLo && temp_acc <= TempHi;
    if (r.valid) begin
      if (streak < startup_m) streak++;
    end else begin
      streak = '0;
    end
    r.ready = r.valid && streak >= startup_m;
    return r;
  endfunction

  function automatic void apply_setting(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    case (idx)
      CfgAlpha:    alpha_m     = val[AlphaW-1:0];
      CfgVbatGain: vbat_gain_m = val[GainW-1:0];
      CfgCurGain:  cur_gain_m  = val[GainW-1:0];
      CfgTempGain: temp_gain_m = val[GainW-1:0];
      CfgStartup:  startup_m   = val[StreakW-1:0];
      default: ;
    endcase
  endfunction

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want)
      report($sformatf("result %0d %s: got %0d, expected %0d", results_out, name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    results_out++;
    if (results_due.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding", results_out));
      return;
    end
    want = results_due.pop_front();
    compare_field("vbat_filtered", $signed(m_tdata[FixW-1:0]), want.vbat);
    compare_field("current_filtered", $signed(m_tdata[2*FixW-1:FixW]), want.cur);
    compare_field("temp_filtered", $signed(m_tdata[3*FixW-1:2*FixW]), want.temp);
    compare_field("tdata padding", m_tdata[OutDataW-1:3*FixW], 0);
    compare_field("sample_valid", m_tuser[0], want.valid);
    compare_field("sensors_ready", m_tuser[1], want.ready);
  endtask

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int draw_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A code whose scaled value stays at or below hi under the given gain.
  function automatic logic [RawW-1:0] code_within(longint hi, logic [GainW-1:0] gain);
    longint lim;
    if (gain == '0) return RawW'($urandom);
    lim = ((hi + 1) * 65536 - 1) / gain;
    if (lim > (1 << RawW) - 1) lim = (1 << RawW) - 1;
    return RawW'($urandom_range(0, lim));
  endfunction

  // Mostly plausible sets so that the streak can build up, some with one channel
  // set to a random code, and some plain noise.
  function automatic raw_set_t next_set();
    raw_set_t s;
    int r;
    r = $urandom_range(0, 99);
    s.vbat = code_within(VbatHi, vbat_gain_m);
    s.cur  = code_within(CurHi, cur_gain_m);
    s.temp = code_within(TempHi, temp_gain_m);
    if (r >= 92) begin
      s = raw_set_t'((3*RawW)'({$urandom, $urandom}));
    end else if (r >= 80) begin
      case ($urandom_range(0, 2))
        0: s.vbat = RawW'($urandom);
        1: s.cur  = RawW'($urandom);
        default: s.temp = RawW'($urandom);
      endcase
    end
    return s;
  endfunction

  // Results are checked before the new expectation is queued, so a set taken
  // at the same edge never pairs with an older result.
  always @(posedge clk_i) begin : track
    if (!rst_ni) begin
      alpha_m     = AlphaRst;
      vbat_gain_m = VbatGainRst;
      cur_gain_m  = CurGainRst;
      temp_gain_m = TempGainRst;
      startup_m   = StartupRst;
      vbat_acc    = '0;
      cur_acc     = '0;
      temp_acc    = '0;
      primed      = 1'b0;
      streak      = '0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) begin
        results_due.push_back(filter_set(raw_set_t'(s_tdata[3*RawW-1:0])));
        plausible_seen += results_due[$].valid;
        ready_seen     += results_due[$].ready;
        sets_in++;
        set_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) apply_setting(cfg_addr, cfg_data);
    end
  end

  always @(negedge clk_i) begin : drive_sets
    logic                nv;
    logic [InDataW-1:0]  nd;
    nv = s_tvalid;
    nd = s_tdata;
    if (set_taken) begin
      nv = 1'b0;
      set_taken = 1'b0;
    end
    if (!nv && rst_ni) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (sets_to_send.size() != 0) begin
        nd = InDataW'(sets_to_send.pop_front());
        nv = 1'b1;
        src_gap = draw_gap(src_calm);
      end
    end
    s_tvalid <= nv;
    s_tdata  <= nd;
  end

  always @(negedge clk_i) begin : drive_sink
    if (snk_stall > 0) begin
      snk_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      snk_stall = draw_gap(snk_calm);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Registers are only touched once nothing is queued or in flight.
  task automatic settle();
    while (sets_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
      @(posedge clk_i);
    phases++;
  endtask

  task automatic queue_set(logic [RawW-1:0] v, logic [RawW-1:0] c, logic [RawW-1:0] t);
    raw_set_t s;
    s.vbat = v;
    s.cur  = c;
    s.temp = t;
    sets_to_send.push_back(s);
  endtask

  function automatic logic [GainW-1:0] pick_gain(logic [GainW-1:0] nominal);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return GainW'($urandom);
      default: return GainW'($urandom_range(nominal / 2, nominal * 2));
    endcase
  endfunction

  task automatic pick_settings();
    logic [CfgDataW-1:0] a;
    logic [CfgDataW-1:0] n;
    case ($urandom_range(0, 9))
      0: a = '0;
      1: a = 65536;
      2: a = CfgDataW'($urandom_range(65537, (1 << AlphaW) - 1));
      3: a = CfgDataW'($urandom);  // bits above the register width are dropped
      default: a = CfgDataW'($urandom_range(1, 65536));
    endcase
    case ($urandom_range(0, 5))
      0: n = '0;
      1: n = 255;
      2: n = CfgDataW'($urandom_range(0, 255));
      default: n = CfgDataW'($urandom_range(1, 12));
    endcase
    write_reg(CfgAlpha, a);
    write_reg(CfgVbatGain, pick_gain(VbatGainRst));
    write_reg(CfgCurGain, pick_gain(CurGainRst));
    write_reg(CfgTempGain, pick_gain(TempGainRst));
    write_reg(CfgStartup, n);
  endtask

  initial begin : stimulus
    int drain;
    drain = 0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults; the first set loads the filters directly.
    queue_set(0, 0, 0);
    queue_set(4095, 4095, 4095);
    queue_set(12'hAAA, 12'h555, 12'hAAA);
    queue_set(12'h555, 12'hAAA, 12'h555);
    repeat (3) queue_set(1000, 1000, 900);

    // Full weight: the state follows the input. Zero startup count: ready follows valid.
    settle();
    write_reg(CfgAlpha, 65536);
    write_reg(CfgStartup, 0);
    queue_set(4095, 4095, 0);
    queue_set(0, 0, 4095);

    // Largest gains saturate the scaled value of a full-scale code.
    settle();
    write_reg(CfgVbatGain, '1);
    write_reg(CfgCurGain, '1);
    write_reg(CfgTempGain, '1);
    queue_set(4095, 4095, 4095);
    queue_set(1, 1, 1);

    // Gains chosen to land exactly on the upper window edges, then one step past.
    settle();
    write_reg(CfgVbatGain, 131072);
    write_reg(CfgCurGain, 131072);
    write_reg(CfgTempGain, 1048576);
    queue_set(2560, 896, 2400);
    queue_set(2561, 897, 2401);

    settle();
    write_reg(CfgVbatGain, '0);
    write_reg(CfgCurGain, '0);
    write_reg(CfgTempGain, '0);
    queue_set(4095, 4095, 4095);

    // Weight above one overshoots, down into negative values and back up.
    settle();
    write_reg(CfgVbatGain, VbatGainRst);
    write_reg(CfgCurGain, CurGainRst);
    write_reg(CfgTempGain, TempGainRst);
    write_reg(CfgAlpha, (1 << AlphaW) - 1);
    queue_set(4095, 4095, 1000);
    queue_set(0, 0, 0);
    queue_set(4095, 4095, 4095);

    // Zero weight holds the state.
    settle();
    write_reg(CfgAlpha, 0);
    queue_set(4095, 0, 4095);

    // Build a streak under the largest count, then lower the count beneath it.
    settle();
    write_reg(CfgAlpha, 65536);
    write_reg(CfgStartup, 255);
    repeat (4) queue_set(500, 500, 500);
    settle();
    write_reg(CfgStartup, 2);
    repeat (2) queue_set(500, 500, 500);

    for (int p = 0; p < RandomPhases; p++) begin
      settle();
      pick_settings();
      src_calm = ($urandom_range(0, 3) == 0);
      snk_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < SetsPerPhase; i++) sets_to_send.push_back(next_set());
    end

    while (sets_to_send.size() != 0 || s_tvalid) @(posedge clk_i);
    while (results_due.size() != 0 && drain < DrainCycles) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (results_due.size() != 0)
      report($sformatf("%0d results never arrived", results_due.size()));

    $display("Sent %0d sets across %0d register settings; checked %0d results.",
             sets_in, phases, results_out);
    $display("Plausible results: %0d, with sensors ready: %0d.", plausible_seen, ready_seen);
    if (fail_count == 0) begin
      $display("[sensor_ema_plausibility] OK");
    end else begin
      $display("[sensor_ema_plausibility] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(ClkPeriod * 500_000);
    $display("Run did not finish in time.");
    $display("[sensor_ema_plausibility] ERROR");
    $finish;
  end

endmodule

[sensor_ema_plausibility.f]
rtl/core/sema_pkg.sv
rtl/core/sema_lane.sv
rtl/core/sema_merge.sv
rtl/core/sensor_ema_plausibility.sv
tb/sensor_ema_plausibility_tb.sv
